// File: src/serial_eeprom_bit_controller_defines.svh
// ----------------------------------------------------------------------------
// Serial EEPROM bit controller assertion macros
// Shared macros for the concurrent checks on the controller's ports.
// ----------------------------------------------------------------------------
`ifndef SERIAL_EEPROM_BIT_CONTROLLER_DEFINES_SVH
`define SERIAL_EEPROM_BIT_CONTROLLER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SEB_ASSERT_ALWAYS(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("seb: property violated");

// A condition that must hold whenever its antecedent holds.
`define SEB_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("seb: implication violated");

// A condition that must hold in the cycle after its antecedent.
`define SEB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("seb: next-cycle implication violated");

`endif

// File: src/seb_pkg.sv
// ----------------------------------------------------------------------------
// Serial EEPROM bit controller package
// Command and action codes, packet lengths and the result record.
// ----------------------------------------------------------------------------
package seb_pkg;

	localparam int unsigned FUNC_W = 2;
	localparam int unsigned ACT_W = 2;
	localparam int unsigned ADDR_W = 14;
	localparam int unsigned DATA_BITS = 64;
	localparam int unsigned READ_BITS = 68;
	localparam int unsigned READ_DUMMY = 4;
	localparam int unsigned HEADER_BITS = 2;
	localparam int unsigned ADDR_LEN_SHORT = 6;
	localparam int unsigned ADDR_LEN_LONG = 14;
	localparam int unsigned IDX_W = 7;
	localparam int unsigned SHIFT_W = 4;

	localparam logic [FUNC_W-1:0] FUNC_SLOT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

	localparam logic [ACT_W-1:0] ACT_IDLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DRIVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic bit_out;
		logic read_done;
		logic [DATA_BITS-1:0] read_data;
		logic write_sent;
	} result_t;

endpackage

// File: src/serial_eeprom_bit_controller.sv
// ----------------------------------------------------------------------------
// Serial EEPROM bit controller
// Sends read and write packets and gathers read data, one bus slot per slot item.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_stall      func, address, write_data, line_in
// out       output     out_valid / out_stall    action, bit_out, read_done,
//                                               read_data, write_sent
// cfg       input      cfg_valid / cfg_ready    short_address
//
// A new item is taken whenever in_stall is low; each bus slot's result is registered.
// The packet state and the output register update in the same clocked block.
// A two-entry output stage (result register plus skid register) lets input
// continue while a result waits; in_stall rises only when both are full.
// Reset clears the packet state, selects short addresses and empties the output.
// cfg_ready is always high.
module serial_eeprom_bit_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [seb_pkg::FUNC_W-1:0]          func,
	input  logic [seb_pkg::ADDR_W-1:0]          address,
	input  logic [seb_pkg::DATA_BITS-1:0]       write_data,
	input  logic                                line_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [seb_pkg::ACT_W-1:0]           action,
	output logic                                bit_out,
	output logic                                read_done,
	output logic [seb_pkg::DATA_BITS-1:0]       read_data,
	output logic                                write_sent,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                short_address
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND_READ,
		PH_RECEIVE,
		PH_SEND_WRITE
	} phase_t;

	phase_t phase_q, phase_d;
	logic [seb_pkg::IDX_W-1:0] idx_q, idx_d;
	logic [seb_pkg::ADDR_W-1:0] addr_q, addr_d;
	logic [seb_pkg::DATA_BITS-1:0] shift_q, shift_d;
	logic short_q;

	seb_pkg::result_t out_q, skid_q, res;
	logic out_valid_q, skid_valid_q, res_valid;

	logic in_acc, out_take;
	logic [seb_pkg::SHIFT_W-1:0] addr_len, addr_sh;
	logic [seb_pkg::IDX_W-1:0] addr_end, data_end;
	logic addr_bit;

	assign in_acc = in_valid & ~in_stall;
	assign out_take = out_valid_q & ~out_stall;
	assign in_stall = skid_valid_q;
	assign cfg_ready = 1'b1;

	assign addr_len = short_q ? seb_pkg::SHIFT_W'(seb_pkg::ADDR_LEN_SHORT)
		: seb_pkg::SHIFT_W'(seb_pkg::ADDR_LEN_LONG);
	assign addr_end = seb_pkg::IDX_W'(seb_pkg::HEADER_BITS) + seb_pkg::IDX_W'(addr_len);
	assign data_end = addr_end + seb_pkg::IDX_W'(seb_pkg::DATA_BITS);
	assign addr_sh = addr_len + seb_pkg::SHIFT_W'(1) - idx_q[seb_pkg::SHIFT_W-1:0];
	assign addr_bit = addr_q[addr_sh];

	always_comb begin
		phase_d = phase_q;
		idx_d = idx_q;
		addr_d = addr_q;
		shift_d = shift_q;
		res = '0;
		res_valid = 1'b0;
		if (in_acc) begin
			case (func)
				seb_pkg::FUNC_READ, seb_pkg::FUNC_WRITE: begin
					if (phase_q == PH_IDLE) begin
						addr_d = address;
						idx_d = '0;
						if (func == seb_pkg::FUNC_READ) begin
							shift_d = '0;
							phase_d = PH_SEND_READ;
						end else begin
							shift_d = write_data;
							phase_d = PH_SEND_WRITE;
						end
					end
				end
				seb_pkg::FUNC_SLOT: begin
					res_valid = 1'b1;
					case (phase_q)
						PH_SEND_READ: begin
							res.action = seb_pkg::ACT_DRIVE;
							if (idx_q < seb_pkg::IDX_W'(seb_pkg::HEADER_BITS)) begin
								res.bit_out = 1'b1;
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end else if (idx_q < addr_end) begin
								res.bit_out = addr_bit;
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end else begin
								phase_d = PH_RECEIVE;
								idx_d = '0;
							end
						end
						PH_RECEIVE: begin
							res.action = seb_pkg::ACT_SAMPLE;
							if (idx_q >= seb_pkg::IDX_W'(seb_pkg::READ_DUMMY)) begin
								shift_d = {shift_q[seb_pkg::DATA_BITS-2:0], line_in};
							end
							if (idx_q >= seb_pkg::IDX_W'(seb_pkg::READ_BITS - 1)) begin
								res.read_done = 1'b1;
								res.read_data = shift_d;
								phase_d = PH_IDLE;
								idx_d = '0;
							end else begin
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end
						end
						PH_SEND_WRITE: begin
							res.action = seb_pkg::ACT_DRIVE;
							if (idx_q < seb_pkg::IDX_W'(seb_pkg::HEADER_BITS)) begin
								res.bit_out = (idx_q == '0);
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end else if (idx_q < addr_end) begin
								res.bit_out = addr_bit;
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end else if (idx_q < data_end) begin
								res.bit_out = shift_q[seb_pkg::DATA_BITS-1];
								shift_d = {shift_q[seb_pkg::DATA_BITS-2:0], 1'b0};
								idx_d = idx_q + seb_pkg::IDX_W'(1);
							end else begin
								res.write_sent = 1'b1;
								phase_d = PH_IDLE;
								idx_d = '0;
							end
						end
						default: begin
							res.action = seb_pkg::ACT_IDLE;
						end
					endcase
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q <= '0;
			addr_q <= '0;
			shift_q <= '0;
			short_q <= 1'b1;
			out_q <= '0;
			skid_q <= '0;
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			addr_q <= addr_d;
			shift_q <= shift_d;
			if (cfg_valid && cfg_ready) begin
				short_q <= short_address;
			end
			if (skid_valid_q) begin
				if (out_take) begin
					out_q <= skid_q;
					skid_valid_q <= 1'b0;
				end
			end else if (res_valid) begin
				if (!out_valid_q || out_take) begin
					out_q <= res;
					out_valid_q <= 1'b1;
				end else begin
					skid_q <= res;
					skid_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign action = out_q.action;
	assign bit_out = out_q.bit_out;
	assign read_done = out_q.read_done;
	assign read_data = out_q.read_data;
	assign write_sent = out_q.write_sent;

endmodule

// File: src/seb_checker.sv
// ----------------------------------------------------------------------------
// Serial EEPROM bit controller checker
// Port-level checks on the controller's result items, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_eeprom_bit_controller_defines.svh"

module seb_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [seb_pkg::ACT_W-1:0]           action,
	input logic                                bit_out,
	input logic                                read_done,
	input logic [seb_pkg::DATA_BITS-1:0]       read_data,
	input logic                                write_sent
);

	`SEB_ASSERT_NEXT(a_out_held, clk, arst_n, out_valid && out_stall, out_valid)
	`SEB_ASSERT_IMPLY(a_done_samples, clk, arst_n, out_valid && read_done, action == seb_pkg::ACT_SAMPLE)
	`SEB_ASSERT_IMPLY(a_sent_drives_stop, clk, arst_n, out_valid && write_sent, action == seb_pkg::ACT_DRIVE && !bit_out)
	`SEB_ASSERT_IMPLY(a_quiet_bit, clk, arst_n, out_valid && action != seb_pkg::ACT_DRIVE, !bit_out)
	`SEB_ASSERT_IMPLY(a_data_only_done, clk, arst_n, out_valid && !read_done, read_data == '0)

endmodule

bind serial_eeprom_bit_controller seb_checker u_seb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.action     (action),
	.bit_out    (bit_out),
	.read_done  (read_done),
	.read_data  (read_data),
	.write_sent (write_sent)
);

// File: dv/serial_eeprom_bit_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial EEPROM bit controller testbench
// Feeds read and write packets, idle slots and ignored commands through the
// controller in both address modes, with random gaps on both channels and
// one long output stall. Every bus slot result is checked field by field
// against a cycle-free model of the packet sequencer.
// ----------------------------------------------------------------------------
module serial_eeprom_bit_controller_tb;

	localparam logic [seb_pkg::FUNC_W-1:0] FUNC_RESERVED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef enum logic [1:0] {ST_IDLE, ST_SEND_READ, ST_RECEIVE, ST_SEND_WRITE} pkt_state_t;

	typedef struct packed {
		logic [seb_pkg::FUNC_W-1:0] func;
		logic [seb_pkg::ADDR_W-1:0] address;
		logic [seb_pkg::DATA_BITS-1:0] write_data;
		logic line_in;
	} bus_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [seb_pkg::FUNC_W-1:0] func = '0;
	logic [seb_pkg::ADDR_W-1:0] address = '0;
	logic [seb_pkg::DATA_BITS-1:0] write_data = '0;
	logic line_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [seb_pkg::ACT_W-1:0] action;
	logic bit_out;
	logic read_done;
	logic [seb_pkg::DATA_BITS-1:0] read_data;
	logic write_sent;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic short_address = 1'b0;

	bus_item_t item_q[$];
	bus_item_t cur_item;
	seb_pkg::result_t slot_results[$];

	pkt_state_t pkt_state = ST_IDLE;
	logic [seb_pkg::IDX_W-1:0] bit_cnt = '0;
	logic [seb_pkg::ADDR_W-1:0] addr_latch = '0;
	logic [seb_pkg::DATA_BITS-1:0] shift_reg = '0;
	logic short_mode = 1'b1;

	int unsigned gap_odds = 0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	int unsigned items_taken = 0;
	int unsigned slots_planned = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	logic long_hold = 1'b0;

	serial_eeprom_bit_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.address(address),
		.write_data(write_data),
		.line_in(line_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.action(action),
		.bit_out(bit_out),
		.read_done(read_done),
		.read_data(read_data),
		.write_sent(write_sent),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.short_address(short_address)
	);

	always #2 clk = ~clk;

	function automatic void predict_slot(input bus_item_t it);
		seb_pkg::result_t r;
		int unsigned len;
		logic [3:0] sh;
		r = '0;
		len = short_mode ? seb_pkg::ADDR_LEN_SHORT : seb_pkg::ADDR_LEN_LONG;
		sh = 4'(len + 1 - bit_cnt);
		if (it.func == seb_pkg::FUNC_READ || it.func == seb_pkg::FUNC_WRITE) begin
			if (pkt_state == ST_IDLE) begin
				addr_latch = it.address;
				bit_cnt = '0;
				if (it.func == seb_pkg::FUNC_READ) begin
					shift_reg = '0;
					pkt_state = ST_SEND_READ;
				end else begin
					shift_reg = it.write_data;
					pkt_state = ST_SEND_WRITE;
				end
			end
			return;
		end
		if (it.func == FUNC_RESERVED)
			return;
		case (pkt_state)
			ST_SEND_READ: begin
				r.action = seb_pkg::ACT_DRIVE;
				if (bit_cnt < seb_pkg::HEADER_BITS) begin
					r.bit_out = 1'b1;
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end else if (bit_cnt < len + seb_pkg::HEADER_BITS) begin
					r.bit_out = addr_latch[sh];
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end else begin
					pkt_state = ST_RECEIVE;
					bit_cnt = '0;
				end
			end
			ST_RECEIVE: begin
				r.action = seb_pkg::ACT_SAMPLE;
				if (bit_cnt >= seb_pkg::READ_DUMMY)
					shift_reg = {shift_reg[seb_pkg::DATA_BITS-2:0], it.line_in};
				if (bit_cnt + 1 >= seb_pkg::READ_BITS) begin
					r.read_done = 1'b1;
					r.read_data = shift_reg;
					pkt_state = ST_IDLE;
					bit_cnt = '0;
				end else begin
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end
			end
			ST_SEND_WRITE: begin
				r.action = seb_pkg::ACT_DRIVE;
				if (bit_cnt < seb_pkg::HEADER_BITS) begin
					r.bit_out = (bit_cnt == '0);
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end else if (bit_cnt < len + seb_pkg::HEADER_BITS) begin
					r.bit_out = addr_latch[sh];
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end else if (bit_cnt < len + seb_pkg::HEADER_BITS + seb_pkg::DATA_BITS) begin
					r.bit_out = shift_reg[seb_pkg::DATA_BITS-1];
					shift_reg = shift_reg << 1;
					bit_cnt = bit_cnt + seb_pkg::IDX_W'(1);
				end else begin
					r.write_sent = 1'b1;
					pkt_state = ST_IDLE;
					bit_cnt = '0;
				end
			end
			default: r.action = seb_pkg::ACT_IDLE;
		endcase
		slot_results.push_back(r);
	endfunction

	function automatic void push_item(input logic [seb_pkg::FUNC_W-1:0] f,
			input logic [seb_pkg::ADDR_W-1:0] a,
			input logic [seb_pkg::DATA_BITS-1:0] d, input logic l);
		bus_item_t it;
		it.func = f;
		it.address = a;
		it.write_data = d;
		it.line_in = l;
		item_q.push_back(it);
		if (f == seb_pkg::FUNC_SLOT)
			slots_planned++;
	endfunction

	function automatic logic [seb_pkg::ADDR_W-1:0] pick_address();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return '1;
			default: return seb_pkg::ADDR_W'($urandom_range(16383, 0));
		endcase
	endfunction

	function automatic logic [seb_pkg::DATA_BITS-1:0] pick_data();
		case ($urandom_range(3, 0))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// A line_fill of 0 or 1 holds the sampled line at that level, 2 randomizes it.
	function automatic void push_packet(input logic is_write,
			input logic [seb_pkg::ADDR_W-1:0] a,
			input logic [seb_pkg::DATA_BITS-1:0] d, input logic inject, input int unsigned len,
			input int unsigned line_fill);
		int unsigned n;
		int unsigned cut;
		int unsigned k;
		n = is_write ? seb_pkg::HEADER_BITS + len + seb_pkg::DATA_BITS + 1
			: seb_pkg::HEADER_BITS + len + 1 + seb_pkg::READ_BITS;
		cut = inject ? $urandom_range(n - 2, 0) : n;
		push_item(is_write ? seb_pkg::FUNC_WRITE : seb_pkg::FUNC_READ, a, d,
			1'($urandom_range(1, 0)));
		for (k = 0; k < n; k++) begin
			if (k == cut)
				push_item($urandom_range(1, 0) ? seb_pkg::FUNC_WRITE : seb_pkg::FUNC_READ,
					pick_address(), pick_data(), 1'($urandom_range(1, 0)));
			push_item(seb_pkg::FUNC_SLOT, seb_pkg::ADDR_W'($urandom_range(16383, 0)),
				{$urandom, $urandom},
				line_fill == 2 ? 1'($urandom_range(1, 0)) : 1'(line_fill));
		end
	endfunction

	function automatic void random_traffic(input int unsigned target, input int unsigned len);
		int unsigned k;
		slots_planned = 0;
		while (slots_planned < target) begin
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4, 5: push_packet(1'($urandom_range(1, 0)), pick_address(),
					pick_data(), 1'b0, len, 2);
				6: push_packet(1'($urandom_range(1, 0)), pick_address(), pick_data(), 1'b1,
					len, 2);
				7, 8: begin
					for (k = $urandom_range(5, 1); k > 0; k--)
						push_item(seb_pkg::FUNC_SLOT, pick_address(), pick_data(),
							1'($urandom_range(1, 0)));
				end
				default: push_item(FUNC_RESERVED, pick_address(), pick_data(),
					1'($urandom_range(1, 0)));
			endcase
		end
	endfunction

	task automatic wait_drained();
		while (item_q.size() != 0 || in_valid || slot_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		cfg_valid <= 1'b1;
		short_address <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		short_mode = v;
	endtask

	task automatic note_mismatch(input string what, input logic [seb_pkg::DATA_BITS-1:0] want,
			input logic [seb_pkg::DATA_BITS-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_slot(cur_item);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (item_q.size() != 0 && gap_odds != 0
						&& $urandom_range(gap_odds - 1, 0) == 0) begin
					in_valid <= 1'b0;
					in_gap = $urandom_range(6, 0);
				end else if (item_q.size() != 0) begin
					cur_item = item_q.pop_front();
					in_valid <= 1'b1;
					func <= cur_item.func;
					address <= cur_item.address;
					write_data <= cur_item.write_data;
					line_in <= cur_item.line_in;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		seb_pkg::result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (slot_results.size() == 0) begin
					note_mismatch("result with nothing expected", '0,
						seb_pkg::DATA_BITS'(action));
				end else begin
					want = slot_results.pop_front();
					if (action !== want.action)
						note_mismatch("action", seb_pkg::DATA_BITS'(want.action),
							seb_pkg::DATA_BITS'(action));
					if (bit_out !== want.bit_out)
						note_mismatch("bit_out", seb_pkg::DATA_BITS'(want.bit_out),
							seb_pkg::DATA_BITS'(bit_out));
					if (read_done !== want.read_done)
						note_mismatch("read_done", seb_pkg::DATA_BITS'(want.read_done),
							seb_pkg::DATA_BITS'(read_done));
					if (read_data !== want.read_data)
						note_mismatch("read_data", want.read_data, read_data);
					if (write_sent !== want.write_sent)
						note_mismatch("write_sent", seb_pkg::DATA_BITS'(want.write_sent),
							seb_pkg::DATA_BITS'(write_sent));
				end
			end
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap--;
			end else if (gap_odds != 0 && $urandom_range(gap_odds - 1, 0) == 0) begin
				out_stall <= 1'b1;
				out_gap = $urandom_range(6, 0);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("serial_eeprom_bit_controller_tb: errors");
			$finish;
		end
	end

	// The output side holds off long enough for the skid stage to fill and
	// push back on the input while the sender keeps offering items.
	initial begin
		@(posedge arst_n);
		while (items_taken < 200)
			@(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b1);
		gap_odds <= 5;

		push_item(seb_pkg::FUNC_SLOT, '0, '0, 1'b0);
		push_item(seb_pkg::FUNC_SLOT, '1, '1, 1'b1);
		push_item(FUNC_RESERVED, '1, '1, 1'b1);
		push_packet(1'b0, '1, '0, 1'b0, seb_pkg::ADDR_LEN_SHORT, 1);
		push_packet(1'b0, '0, '1, 1'b0, seb_pkg::ADDR_LEN_SHORT, 0);
		push_packet(1'b1, 14'h3FFF, '1, 1'b0, seb_pkg::ADDR_LEN_SHORT, 2);
		push_packet(1'b1, '0, '0, 1'b1, seb_pkg::ADDR_LEN_SHORT, 2);
		push_packet(1'b0, 14'h2A15, 64'h0123_4567_89AB_CDEF, 1'b1, seb_pkg::ADDR_LEN_SHORT, 2);
		push_item(FUNC_RESERVED, '0, '0, 1'b0);
		push_item(seb_pkg::FUNC_SLOT, '0, '0, 1'b1);
		random_traffic(220, seb_pkg::ADDR_LEN_SHORT);
		wait_drained();

		write_mode(1'b0);
		gap_odds <= 6;
		push_packet(1'b0, '1, '0, 1'b0, seb_pkg::ADDR_LEN_LONG, 1);
		push_packet(1'b1, '1, '1, 1'b0, seb_pkg::ADDR_LEN_LONG, 2);
		random_traffic(260, seb_pkg::ADDR_LEN_LONG);
		wait_drained();

		write_mode(1'b1);
		gap_odds <= 3;
		random_traffic(260, seb_pkg::ADDR_LEN_SHORT);
		wait_drained();

		write_mode(1'b0);
		gap_odds <= 0;
		random_traffic(260, seb_pkg::ADDR_LEN_LONG);
		wait_drained();

		if (mismatches == 0)
			$display("serial_eeprom_bit_controller_tb: clean");
		else
			$display("serial_eeprom_bit_controller_tb: errors");
		$finish;
	end

endmodule
